@@ hdl/aaqr_pkg.sv @@
// Package for the axis-angle quaternion rotation block.
// Holds fixed-point constants, the CORDIC arctangent table and the stream word types.
`default_nettype none
package aaqr_pkg;
    localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] v;
        begin
            case (i)
                5'd0: v = 36'sd843314856;  5'd1: v = 36'sd497837829;
                5'd2: v = 36'sd263043836;  5'd3: v = 36'sd133525158;
                5'd4: v = 36'sd67021686;   5'd5: v = 36'sd33543515;
                5'd6: v = 36'sd16775850;   5'd7: v = 36'sd8388437;
                5'd8: v = 36'sd4194282;    5'd9: v = 36'sd2097149;
                5'd10: v = 36'sd1048575;   5'd11: v = 36'sd524287;
                5'd12: v = 36'sd262143;    5'd13: v = 36'sd131071;
                5'd14: v = 36'sd65535;     5'd15: v = 36'sd32767;
                5'd16: v = 36'sd16383;     5'd17: v = 36'sd8191;
                5'd18: v = 36'sd4095;      5'd19: v = 36'sd2047;
                5'd20: v = 36'sd1023;      5'd21: v = 36'sd511;
                5'd22: v = 36'sd255;       5'd23: v = 36'sd127;
                5'd24: v = 36'sd63;        5'd25: v = 36'sd31;
                5'd26: v = 36'sd15;        5'd27: v = 36'sd8;
                5'd28: v = 36'sd4;         5'd29: v = 36'sd2;
                5'd30: v = 36'sd1;         default: v = 36'sd0;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] angle;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] rotated_x;
        logic signed [31:0] rotated_y;
        logic signed [31:0] rotated_z;
    } t_out_word;
endpackage
`default_nettype wire

@@ hdl/aaqr_if.sv @@
// Valid/ready stream interfaces for the rotation block's input and output words.
// Depends on aaqr_pkg for the payload types.
`default_nettype none
interface aaqr_in_if;
    logic valid;
    logic ready;
    aaqr_pkg::t_in_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface aaqr_out_if;
    logic valid;
    logic ready;
    aaqr_pkg::t_out_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/axis_angle_quaternion_rotate.sv @@
// Throughput: one word per cycle; the whole pipeline advances when the output
// register is free or being taken, so a stall holds every stage in place.
// Longest stages: the 32-step restoring square root and 32-step divide units.
// Reset (i_rst_n, synchronous, active low) clears only the stage valid bits.
`default_nettype none
module axis_angle_quaternion_rotate #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    aaqr_in_if.sink    s_in,
    aaqr_out_if.source m_out
);
    import aaqr_pkg::*;

    // Stage map: 0 capture, 1-2 normalize shift, 3 squares, 4 sum,
    // 5..36 square root (32), 37..68 divide (32), 69 sign and half-angle fold.
    localparam int SQ0  = 5;
    localparam int SQN  = 32;
    localparam int DV0  = SQ0 + SQN;       // divide steps, one quotient bit each
    localparam int DVN  = 32;
    localparam int CR0  = DV0 + DVN + 1;   // after sign and half-angle fold stage
    localparam int MU0  = CR0 + CORDIC_STEPS + 1;
    localparam int NST  = MU0 + 8;

    logic adv;
    logic [NST-1:0] r_v;
    assign adv = !m_out.valid || m_out.ready;
    assign s_in.ready = adv;

    // Per-stage payload.
    typedef struct packed {
        logic bypass;
        logic big;
        logic [2:0] neg;
        logic [2:0][31:0] mag;
        logic [65:0] rem;
        logic [32:0] root;
        logic [2:0][63:0] drem;
        logic [2:0][31:0] quo;
        logic signed [35:0] z, x, y;
        logic flip;
        logic signed [2:0][31:0] n;
        logic signed [2:0][31:0] pt;
        logic signed [35:0] c;
        logic signed [3:0][35:0] q;
        logic signed [3:0][35:0] t;
    } t_stage;

    t_stage r_s [NST];
    t_stage n_s [NST];

    function automatic logic signed [35:0] rnd30(input logic signed [99:0] a);
        logic signed [99:0] b;
        begin
            b = (a + 100'sd536870912) >>> 30;
            return b[35:0];
        end
    endfunction

    always_comb begin
        logic [31:0] mx;
        logic [65:0] trial;
        logic [64:0] dtrial;
        logic signed [35:0] dx, dy;
        logic signed [35:0] zz;
        logic signed [99:0] acc;
        logic signed [35:0] a0, a1, a2, a3, b0, b1, b2, b3;
        logic signed [35:0] v;
        int k;
        n_s[0] = '0;
        for (int s = 1; s < NST; s++) n_s[s] = r_s[s-1];
        // Stage 0: capture, sign/magnitude.
        n_s[0].pt[0] = s_in.data.point_x;
        n_s[0].pt[1] = s_in.data.point_y;
        n_s[0].pt[2] = s_in.data.point_z;
        n_s[0].z = {{4{s_in.data.angle[31]}}, s_in.data.angle};
        n_s[0].bypass = (s_in.data.axis_x == 0 && s_in.data.axis_y == 0 &&
                         s_in.data.axis_z == 0) || s_in.data.angle == 0;
        n_s[0].neg = {s_in.data.axis_z[31], s_in.data.axis_y[31], s_in.data.axis_x[31]};
        n_s[0].mag[0] = s_in.data.axis_x[31] ? 32'(-s_in.data.axis_x) : s_in.data.axis_x;
        n_s[0].mag[1] = s_in.data.axis_y[31] ? 32'(-s_in.data.axis_y) : s_in.data.axis_y;
        n_s[0].mag[2] = s_in.data.axis_z[31] ? 32'(-s_in.data.axis_z) : s_in.data.axis_z;
        // Stage 1: coarse shift (right 2, or left 16).
        mx = r_s[0].mag[0];
        if (r_s[0].mag[1] > mx) mx = r_s[0].mag[1];
        if (r_s[0].mag[2] > mx) mx = r_s[0].mag[2];
        n_s[1].big = (mx >= 32'h4000_0000);
        if (mx >= 32'h4000_0000) begin
            for (int i = 0; i < 3; i++) n_s[1].mag[i] = r_s[0].mag[i] >> 2;
        end else begin
            k = 0;
            if (mx[29:14] == 0 && mx != 0) k = 16;
            for (int i = 0; i < 3; i++) n_s[1].mag[i] = r_s[0].mag[i] << k;
        end
        // Stage 2: fine shift, so that the largest magnitude reaches 2^29.
        mx = r_s[1].mag[0];
        if (r_s[1].mag[1] > mx) mx = r_s[1].mag[1];
        if (r_s[1].mag[2] > mx) mx = r_s[1].mag[2];
        k = 0;
        if (mx != 0 && !r_s[1].big) begin
            for (int b = 0; b < 16; b++) if (mx < (32'd1 << (29 - b))) k = b + 1;
        end
        for (int i = 0; i < 3; i++) n_s[2].mag[i] = r_s[1].mag[i] << k;
        // Stage 3: squares, held in the drem fields; one register per square.
        n_s[3].drem[0] = 64'(r_s[2].mag[0]) * 64'(r_s[2].mag[0]);
        n_s[3].drem[1] = 64'(r_s[2].mag[1]) * 64'(r_s[2].mag[1]);
        n_s[3].drem[2] = 64'(r_s[2].mag[2]) * 64'(r_s[2].mag[2]);
        // Stage 4: sum of squares, root init.
        n_s[4].rem = 66'(r_s[3].drem[0]) + 66'(r_s[3].drem[1]) + 66'(r_s[3].drem[2]);
        n_s[4].root = '0;
        // Square root: one result bit per stage.
        for (int j = 0; j < SQN; j++) begin
            trial = 66'({r_s[SQ0+j-1].root[31:0], 2'b01}) << (2*(31-j));
            if (r_s[SQ0+j-1].rem >= trial) begin
                n_s[SQ0+j].rem = r_s[SQ0+j-1].rem - trial;
                n_s[SQ0+j].root = {r_s[SQ0+j-1].root[31:0], 1'b1};
            end else begin
                n_s[SQ0+j].root = {r_s[SQ0+j-1].root[31:0], 1'b0};
            end
            if (j == SQN-1) begin
                if (n_s[SQ0+j].root == 0) n_s[SQ0+j].root = 33'd1;
                for (int i = 0; i < 3; i++) begin
                    n_s[SQ0+j].drem[i] = 64'({r_s[SQ0+j-1].mag[i], 30'd0})
                                         + 64'(n_s[SQ0+j].root[32:1]);
                    n_s[SQ0+j].quo[i] = '0;
                end
            end
        end
        // Divide: numerator < 2^62, quotient < 2^32; one bit per stage.
        for (int j = 0; j < DVN; j++) begin
            for (int i = 0; i < 3; i++) begin
                dtrial = 65'(r_s[DV0+j-1].root) << (31-j);
                if (65'(r_s[DV0+j-1].drem[i]) >= dtrial) begin
                    n_s[DV0+j].drem[i] = r_s[DV0+j-1].drem[i] - dtrial[63:0];
                    n_s[DV0+j].quo[i] = {r_s[DV0+j-1].quo[i][30:0], 1'b1};
                end else begin
                    n_s[DV0+j].quo[i] = {r_s[DV0+j-1].quo[i][30:0], 1'b0};
                end
            end
        end
        // Signed unit axis and half-angle reduction.
        for (int i = 0; i < 3; i++)
            n_s[CR0-1].n[i] = r_s[CR0-2].neg[i] ? -r_s[CR0-2].quo[i] : r_s[CR0-2].quo[i];
        zz = r_s[CR0-2].z <<< 1;
        n_s[CR0-1].flip = 1'b0;
        if (zz > HALF_PI_Q30) begin
            zz = zz - PI_Q30; n_s[CR0-1].flip = 1'b1;
        end else if (zz < -HALF_PI_Q30) begin
            zz = zz + PI_Q30; n_s[CR0-1].flip = 1'b1;
        end
        n_s[CR0-1].z = zz;
        n_s[CR0-1].x = CORDIC_GAIN;
        n_s[CR0-1].y = '0;
        // CORDIC, one micro-rotation per stage.
        for (int j = 0; j < CORDIC_STEPS; j++) begin
            dx = r_s[CR0+j-1].y >>> (j & 31);
            dy = r_s[CR0+j-1].x >>> (j & 31);
            if (!r_s[CR0+j-1].z[35]) begin
                n_s[CR0+j].x = r_s[CR0+j-1].x - dx;
                n_s[CR0+j].y = r_s[CR0+j-1].y + dy;
                n_s[CR0+j].z = r_s[CR0+j-1].z - atan_q30(5'(j));
            end else begin
                n_s[CR0+j].x = r_s[CR0+j-1].x + dx;
                n_s[CR0+j].y = r_s[CR0+j-1].y - dy;
                n_s[CR0+j].z = r_s[CR0+j-1].z + atan_q30(5'(j));
            end
        end
        // q = (c, n*s).
        v = r_s[MU0-1].flip ? -r_s[MU0-1].y : r_s[MU0-1].y;
        n_s[MU0].c = r_s[MU0-1].flip ? -r_s[MU0-1].x : r_s[MU0-1].x;
        n_s[MU0].q[0] = n_s[MU0].c;
        for (int i = 0; i < 3; i++)
            n_s[MU0].q[i+1] = rnd30(100'($signed(r_s[MU0-1].n[i])) * 100'(v));
        // t = q' * p, with p = (0, point).
        a0 = r_s[MU0].q[0]; a1 = -r_s[MU0].q[1]; a2 = -r_s[MU0].q[2]; a3 = -r_s[MU0].q[3];
        b1 = 36'($signed(r_s[MU0].pt[0]));
        b2 = 36'($signed(r_s[MU0].pt[1]));
        b3 = 36'($signed(r_s[MU0].pt[2]));
        n_s[MU0+1].t[0] = rnd30(-100'(a1)*b1 - 100'(a2)*b2 - 100'(a3)*b3);
        n_s[MU0+1].t[1] = rnd30(100'(a0)*b1 + 100'(a2)*b3 - 100'(a3)*b2);
        n_s[MU0+1].t[2] = rnd30(100'(a0)*b2 + 100'(a3)*b1 - 100'(a1)*b3);
        n_s[MU0+1].t[3] = rnd30(100'(a0)*b3 + 100'(a1)*b2 - 100'(a2)*b1);
        // r = t * q, vector part.
        a0 = r_s[MU0+1].t[0]; a1 = r_s[MU0+1].t[1]; a2 = r_s[MU0+1].t[2]; a3 = r_s[MU0+1].t[3];
        b0 = r_s[MU0+1].q[0]; b1 = r_s[MU0+1].q[1]; b2 = r_s[MU0+1].q[2]; b3 = r_s[MU0+1].q[3];
        acc = 100'(a0)*b1 + 100'(b0)*a1 + 100'(a2)*b3 - 100'(a3)*b2;
        n_s[MU0+2].c = rnd30(acc);
        acc = 100'(a0)*b2 + 100'(b0)*a2 + 100'(a3)*b1 - 100'(a1)*b3;
        n_s[MU0+2].x = rnd30(acc);
        acc = 100'(a0)*b3 + 100'(b0)*a3 + 100'(a1)*b2 - 100'(a2)*b1;
        n_s[MU0+2].y = rnd30(acc);
        for (int s = MU0+3; s < NST; s++) n_s[s] = r_s[s-1];
    end

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -36'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NST-2:0], s_in.valid};
        end
        if (adv) for (int s = 0; s < NST; s++) r_s[s] <= n_s[s];
    end

    // Output word from the last stage.
    assign m_out.valid = r_v[NST-1];
    assign m_out.data.rotated_x = r_s[NST-1].bypass ? r_s[NST-1].pt[0] : sat32(r_s[NST-1].c);
    assign m_out.data.rotated_y = r_s[NST-1].bypass ? r_s[NST-1].pt[1] : sat32(r_s[NST-1].x);
    assign m_out.data.rotated_z = r_s[NST-1].bypass ? r_s[NST-1].pt[2] : sat32(r_s[NST-1].y);

    // A stalled output word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("output word changed under stall");
    // Ready follows the output register.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready)
        else $error("input blocked with empty output");
    // An accepted word enters the first stage.
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> r_v[0])
        else $error("accepted word lost");
endmodule
`default_nettype wire

@@ tb/axis_angle_quaternion_rotate_test.sv @@
// Self-checking testbench for axis_angle_quaternion_rotate.
// Depends on aaqr_pkg and the stream interfaces in aaqr_if. A scoreboard class predicts
// each rotated word, and plain tasks drive the valid/ready streams.
`timescale 1ns / 100ps
`default_nettype none
module axis_angle_quaternion_rotate_test;
    import aaqr_pkg::*;

    localparam int STEPS = 24;
    localparam int LATENCY = STEPS + 78;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1850;

    // Predicts rotated words and checks them against the block's output.
    class rotation_scoreboard;
        t_out_word expected_rotations[$];
        int mismatches = 0;

        // Arctangent of 2^-i in Q2.30.
        longint arctan_q30[32] = '{
            843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
            16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
            131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
            127, 63, 31, 15, 8, 4, 2, 1, 0};

        function longint round_q30(longint acc);
            return (acc + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Hamilton product in w,x,y,z order, rescaled by 2^-30.
        function void hamilton(input longint a[4], input longint b[4], output longint o[4]);
            o[0] = round_q30(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
            o[1] = round_q30(a[0]*b[1] + b[0]*a[1] + a[2]*b[3] - a[3]*b[2]);
            o[2] = round_q30(a[0]*b[2] + b[0]*a[2] + a[3]*b[1] - a[1]*b[3]);
            o[3] = round_q30(a[0]*b[3] + b[0]*a[3] + a[1]*b[2] - a[2]*b[1]);
        endfunction

        function logic signed [31:0] saturate(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function t_out_word rotate_point(t_in_word w);
            longint ax[3], pt[3], n[3];
            longint z, x, y, c, s, dx, dy, sv;
            longint unsigned mag[3];
            longint unsigned m, sum, len;
            bit neg[3];
            bit flip;
            longint q[4], qc[4], p[4], t[4], r[4];
            t_out_word o;
            ax[0] = w.axis_x;  ax[1] = w.axis_y;  ax[2] = w.axis_z;
            pt[0] = w.point_x; pt[1] = w.point_y; pt[2] = w.point_z;
            z = w.angle;
            // A zero axis or a zero angle leaves the point as it is.
            if ((ax[0] == 0 && ax[1] == 0 && ax[2] == 0) || z == 0) begin
                o.rotated_x = w.point_x;
                o.rotated_y = w.point_y;
                o.rotated_z = w.point_z;
                return o;
            end
            // Bring the largest magnitude into range, then normalise the axis.
            m = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = ax[i] < 0;
                mag[i] = neg[i] ? longint'(-ax[i]) : longint'(ax[i]);
                if (mag[i] > m) m = mag[i];
            end
            if (m >= (64'd1 << 30)) begin
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 2;
            end else begin
                while (m < (64'd1 << 29)) begin
                    m = m << 1;
                    for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
                end
            end
            sum = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
            len = floor_sqrt(sum);
            if (len == 0) len = 1;
            for (int i = 0; i < 3; i++) begin
                sv = longint'(((mag[i] << 30) + (len >> 1)) / len);
                n[i] = neg[i] ? -sv : sv;
            end
            // Half angle to Q2.30, folded once into plus or minus pi/2.
            z = z * 2;
            flip = 0;
            if (z > 64'sd1686629713) begin
                z = z - 64'sd3373259426;
                flip = 1;
            end else if (z < -64'sd1686629713) begin
                z = z + 64'sd3373259426;
                flip = 1;
            end
            x = 64'sd652032874;
            y = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> (i % 32);
                dy = x >>> (i % 32);
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - arctan_q30[i % 32];
                end else begin
                    x = x + dx; y = y - dy; z = z + arctan_q30[i % 32];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
            q[0] = c;
            qc[0] = c;
            p[0] = 0;
            for (int i = 0; i < 3; i++) begin
                q[i+1] = round_q30(n[i] * s);
                qc[i+1] = -q[i+1];
                p[i+1] = pt[i];
            end
            hamilton(qc, p, t);
            hamilton(t, q, r);
            o.rotated_x = saturate(r[1]);
            o.rotated_y = saturate(r[2]);
            o.rotated_z = saturate(r[3]);
            return o;
        endfunction

        function void note_input(t_in_word w);
            expected_rotations.push_back(rotate_point(w));
        endfunction

        function void check_output(t_out_word got);
            t_out_word want;
            if (expected_rotations.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output word %h %h %h",
                             got.rotated_x, got.rotated_y, got.rotated_z);
                return;
            end
            want = expected_rotations.pop_front();
            if (got.rotated_x !== want.rotated_x || got.rotated_y !== want.rotated_y ||
                got.rotated_z !== want.rotated_z) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h %h %h, got %h %h %h",
                             want.rotated_x, want.rotated_y, want.rotated_z,
                             got.rotated_x, got.rotated_y, got.rotated_z);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    aaqr_in_if s_in();
    aaqr_out_if m_out();

    rotation_scoreboard board;
    int send_idle_pct;
    int take_idle_pct;
    int cycles;

    axis_angle_quaternion_rotate #(.CORDIC_STEPS(STEPS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_in(s_in),
        .m_out(m_out)
    );

    // Clock generation.
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit, in case the block never delivers.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver readiness, idling at the current rate.
    always @(posedge i_clk) begin
        m_out.ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Every accepted output word is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && m_out.valid && m_out.ready)
            board.check_output(m_out.data);
    end

    // Offers one word, with random idle cycles first, and waits for acceptance.
    task automatic send_word(t_in_word w);
        if ($urandom_range(99) < send_idle_pct) begin
            s_in.valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_in.valid <= 1;
        s_in.data <= w;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        board.note_input(w);
    endtask

    task automatic send_fields(int ax, int ay, int az, int px, int py, int pz, int ang);
        t_in_word w;
        w.axis_x = ax; w.axis_y = ay; w.axis_z = az;
        w.point_x = px; w.point_y = py; w.point_z = pz;
        w.angle = ang;
        send_word(w);
    endtask

    function automatic int small_signed(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    // Mostly sensible rotations, with full-range noise and the pass-through cases.
    task automatic send_random_word();
        t_in_word w;
        int kind;
        kind = $urandom_range(9);
        w.axis_x = $urandom; w.axis_y = $urandom; w.axis_z = $urandom;
        w.point_x = $urandom; w.point_y = $urandom; w.point_z = $urandom;
        w.angle = $urandom;
        if (kind >= 1 && kind <= 6) begin
            w.axis_x = small_signed(1 << ($urandom_range(30)));
            w.axis_y = small_signed(1 << ($urandom_range(30)));
            w.axis_z = small_signed(1 << ($urandom_range(30)));
            w.point_x = small_signed(1 << 24);
            w.point_y = small_signed(1 << 24);
            w.point_z = small_signed(1 << 24);
        end else if (kind == 7) begin
            w.axis_x = 0; w.axis_y = 0; w.axis_z = 0;
        end else if (kind == 8) begin
            w.angle = 0;
        end else if (kind == 9) begin
            w.axis_x = small_signed(2); w.axis_y = 0; w.axis_z = 0;
        end
        send_word(w);
    endtask

    // The sender stops offering words until every expected result has come.
    task automatic wait_drained();
        s_in.valid <= 0;
        while (board.expected_rotations.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        cycles = 0;
        send_idle_pct = 18;
        take_idle_pct = 55;
        i_rst_n = 0;
        s_in.valid = 0;
        s_in.data = '0;
        m_out.ready = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed words: pass-through, extremes, saturation and fold boundaries.
        send_fields(0, 0, 0, 32'h7fffffff, 32'h80000000, 12345, 32'h10000000);
        send_fields(65536, 0, 0, -1, 1, 32'h7fffffff, 0);
        send_fields(65536, 0, 0, 65536, 65536, 0, 32'h10000000);
        send_fields(0, 65536, 0, 65536, 0, 65536, 32'h3243f6a8);
        send_fields(0, 0, 65536, 65536, 131072, 0, -32'sh3243f6a8);
        send_fields(32'h80000000, 32'h80000000, 32'h80000000, 1 << 20, 2 << 20, 3 << 20,
                    32'h7fffffff);
        send_fields(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 32'h80000000);
        send_fields(1, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h20000000);
        send_fields(1, -1, 1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h1921fb54);
        send_fields(-1, 0, 0, 1000, -1000, 500, 32'h3243f6a9);
        send_fields(0, 0, -1, 1000, -1000, 500, -32'sh3243f6a9);
        send_fields(1 << 30, 0, 0, 0, 1 << 16, 0, 1);
        send_fields((1 << 30) - 1, 1, 0, 0, 1 << 16, 0, -1);
        send_fields(3, 4, 12, 7 << 16, -5 << 16, 2 << 16, 32'h6487ed51);
        send_fields(65536, 65536, 65536, 32'h7fffffff, 0, 32'h80000000, 32'h19000000);

        // Hold off until every directed result has come back.
        wait_drained();

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS / 3) begin
                send_idle_pct = 55;
                take_idle_pct = 18;
            end else if (k == 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            send_random_word();
        end
        s_in.valid <= 0;

        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_rotations.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
